FILE: design/rdnfa_pkg.sv
// Shared types and constants for the dot-star automaton matcher.
`default_nettype none

package rdnfa_pkg;

  // Atom slots held in the two pattern registers.
  localparam int ATOM_SLOTS  = 16;
  localparam int ATOM_W      = 6;
  localparam int CODE_W      = 5;
  localparam int SYM_W       = 5;
  localparam int COUNT_W     = 5;
  localparam int ATOM_BANK_W = 48;
  localparam int CFG_DATA_W  = 48;
  localparam int CFG_IDX_W   = 2;

  localparam int DEFAULT_MAX_ATOMS = 16;

  localparam logic [CODE_W-1:0] LAST_LETTER = 5'd25;
  localparam logic [CODE_W-1:0] ANY_CODE    = 5'd26;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ATOM_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATOMS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATOMS_HIGH = 2'd2;

  // Signals one cell hands to the next position.
  typedef struct packed {
    logic cur;  // current set closed over a starred atom
    logic adv;  // plain atom consumed the symbol
    logic set;  // new set closed over a starred atom
  } rdnfa_link_t;

  typedef struct packed {
    logic alive;
    logic matched;
  } rdnfa_result_t;

endpackage

`default_nettype wire

FILE: design/rdnfa_cell.sv
// One pattern position of the automaton: state bit, atom test and closure links.
`default_nettype none

module rdnfa_cell (
  input  logic [rdnfa_pkg::ATOM_W-1:0] atom,
  input  logic                         en,       // an atom follows this position
  input  logic                         in_range, // position is within the pattern
  input  logic                         is_last,  // position equals the atom count
  input  logic                         restart,
  input  logic                         seed,     // start bit for a new text
  input  logic [rdnfa_pkg::SYM_W-1:0]  symbol,
  input  logic                         state_bit,
  input  rdnfa_pkg::rdnfa_link_t       link_in,
  output rdnfa_pkg::rdnfa_link_t       link_out,
  output logic                         set_bit,
  output logic                         match_bit
);
  import rdnfa_pkg::*;

  logic [CODE_W-1:0] code;
  logic              star;
  logic              hit;
  logic              cur;
  logic              pre;
  logic              set_raw;

  assign code = atom[CODE_W-1:0];
  assign star = atom[ATOM_W-1];
  assign hit  = (code == ANY_CODE) || ((code <= LAST_LETTER) && (code == symbol));

  // Stored set, closed again here in case the pattern changed since it was kept.
  assign cur = state_bit | link_in.cur;

  assign pre     = restart ? seed : ((cur & en & hit & star) | link_in.adv);
  assign set_raw = pre | link_in.set;

  assign link_out.cur = cur & en & star;
  assign link_out.adv = cur & en & hit & ~star;
  assign link_out.set = set_raw & en & star;

  assign set_bit   = set_raw & in_range;
  assign match_bit = set_raw & is_last;

endmodule

`default_nettype wire

FILE: design/rdnfa_out_buf.sv
// Result register with a skid entry so the input side keeps moving under stalls.
`default_nettype none

module rdnfa_out_buf (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  rdnfa_pkg::rdnfa_result_t in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output rdnfa_pkg::rdnfa_result_t out_data
);
  import rdnfa_pkg::*;

  logic          skid_valid;
  rdnfa_result_t skid_data;
  logic          push;
  logic          out_free;

  assign in_ready = ~skid_valid;
  assign push     = in_valid & in_ready;
  assign out_free = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid_data : in_data;
    end
    if (push && !out_free) begin
      skid_data <= in_data;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register is empty");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    (push && out_valid && !out_ready) |=> skid_valid)
    else $error("word accepted under stall was not kept in the skid entry");

  a_skid_drains_first: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_ready) |=> (out_valid && !skid_valid))
    else $error("skid entry did not move to the output register");

endmodule

`default_nettype wire

FILE: design/regex_dot_star_nfa_matcher_core.sv
// Top level of the streaming dot-star pattern matcher built as a row of position cells.
//
//  channel  direction  contents
//  s_*      in         tuser: mode (1 = new text); tdata[4:0]: symbol
//  m_*      out        tdata[0]: matched, tdata[1]: alive
//  cfg_*    in         cfg_index selects atom_count, atoms_low or atoms_high
//
// One word per cycle while s_tready is high: each accepted word updates the active
// set in the same cycle through the cell row, whose two closure ripples set the
// critical path. Results leave through the registered output buffer on m_*.
// Reset leaves only position zero active and clears all configuration.
// A two-entry output buffer keeps s_tready high across a single stalled result.
`default_nettype none

module regex_dot_star_nfa_matcher_core #(
  parameter int MAX_ATOMS = rdnfa_pkg::DEFAULT_MAX_ATOMS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // [4:0] symbol
  input  logic                             s_tuser,   // [0] mode
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [7:0]                       m_tdata,   // [0] matched, [1] alive
  input  logic                             cfg_we,
  input  logic [rdnfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rdnfa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rdnfa_pkg::*;

  localparam int NUM_ATOMS = (MAX_ATOMS < ATOM_SLOTS) ? MAX_ATOMS : ATOM_SLOTS;
  localparam int NUM_POS   = NUM_ATOMS + 1;

  logic [COUNT_W-1:0]     atom_count;
  logic [ATOM_BANK_W-1:0] atoms_low;
  logic [ATOM_BANK_W-1:0] atoms_high;
  logic [NUM_POS-1:0]     active;

  logic [COUNT_W-1:0]            used;
  logic [2*ATOM_BANK_W-1:0]      atoms_all;
  rdnfa_link_t [NUM_POS:0]       links;
  logic [NUM_POS-1:0]            set_bits;
  logic [NUM_POS-1:0]            match_bits;
  logic                          accept;
  rdnfa_result_t                 result;
  rdnfa_result_t                 out_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      atom_count <= '0;
      atoms_low  <= '0;
      atoms_high <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ATOM_COUNT: atom_count <= cfg_data[COUNT_W-1:0];
        REG_ATOMS_LOW:  atoms_low  <= cfg_data[ATOM_BANK_W-1:0];
        REG_ATOMS_HIGH: atoms_high <= cfg_data[ATOM_BANK_W-1:0];
        default: ;
      endcase
    end
  end

  assign used      = (atom_count > COUNT_W'(NUM_ATOMS)) ? COUNT_W'(NUM_ATOMS) : atom_count;
  assign atoms_all = {atoms_high, atoms_low};
  assign links[0]  = '0;

  genvar i;
  generate
    for (i = 0; i < NUM_POS; i++) begin : g_pos
      logic [ATOM_W-1:0] atom;
      if (i < NUM_ATOMS) begin : g_atom
        assign atom = atoms_all[i*ATOM_W +: ATOM_W];
      end else begin : g_end
        assign atom = '0;
      end

      rdnfa_cell u_cell (
        .atom      (atom),
        .en        (COUNT_W'(i) < used),
        .in_range  (COUNT_W'(i) <= used),
        .is_last   (COUNT_W'(i) == used),
        .restart   (s_tuser),
        .seed      (i == 0),
        .symbol    (s_tdata[SYM_W-1:0]),
        .state_bit (active[i]),
        .link_in   (links[i]),
        .link_out  (links[i+1]),
        .set_bit   (set_bits[i]),
        .match_bit (match_bits[i])
      );
    end
  endgenerate

  assign accept         = s_tvalid & s_tready;
  assign result.matched = |match_bits;
  assign result.alive   = |set_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= NUM_POS'(1);
    end else if (accept) begin
      active <= set_bits;
    end
  end

  rdnfa_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (result),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_result)
  );

  assign m_tdata = {6'b0, out_result.alive, out_result.matched};

  a_restart_seeds: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser) |=> active[0])
    else $error("new text did not activate position zero");

  a_word_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted word produced no result");

  a_restart_alive: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser) |-> result.alive)
    else $error("new text reported no live position");

endmodule

`default_nettype wire
